// ===== rtl/core/pidtr_pkg.sv =====
// pidtr_pkg: shared widths, reset values, register indexes and stage control type
// for the pid torque regulator core; no dependencies
package pidtr_pkg;

   // default parameter values
   localparam int SAMPLE_WIDTH_DEF    = 16;
   localparam int GAIN_FRAC_BITS_DEF  = 16;

   // fixed formats
   localparam int SAMPLE_FRAC         = 4;
   localparam int GAIN_WIDTH          = 32;
   localparam int ERROR_SUM_WIDTH     = 32;
   localparam int DEAD_BAND_WIDTH     = 15;
   localparam int LIMIT_WIDTH         = 16;
   localparam int DUTY_WIDTH          = 16;
   localparam int DRIVE_WIDTH         = 17;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int RSP_TDATA_WIDTH     = 40;

   // register reset values
   localparam logic [DEAD_BAND_WIDTH-1:0] DEAD_BAND_RESET = 15'd13;
   localparam logic [LIMIT_WIDTH-1:0]     LIMIT_RESET     = 16'd499;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PROP_GAIN     = 3'd0,
      CSR_INTEGRAL_GAIN = 3'd1,
      CSR_DERIV_GAIN    = 3'd2,
      CSR_DEAD_BAND     = 3'd3,
      CSR_OUTPUT_LIMIT  = 3'd4
   } csr_index_type;

   // control carried alongside each item through the stages
   typedef struct packed {
      logic valid;
      logic direction_flag;
      logic direction_toggled;
   } pidtr_ctrl_type;

endpackage

// ===== rtl/core/pidtr_front.sv =====
// pidtr_front: input register, deadband error, saturating error sum, measurement
// delta and direction state; depends on pidtr_pkg
module pidtr_front #(
   parameter int SAMPLE_WIDTH = pidtr_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         advance,
   input  logic                                         in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0]               reference,
   input  logic signed [SAMPLE_WIDTH-1:0]               measurement,
   input  logic                                         direction_request,
   input  logic                                         integral_on,
   input  logic                                         deriv_on,
   input  logic [pidtr_pkg::DEAD_BAND_WIDTH-1:0]        dead_band,
   input  logic                                         state_clear,
   output pidtr_pkg::pidtr_ctrl_type                    ctrl,
   output logic signed [SAMPLE_WIDTH:0]                 error,
   output logic signed [pidtr_pkg::ERROR_SUM_WIDTH-1:0] error_sum,
   output logic signed [SAMPLE_WIDTH:0]                 meas_delta
);

   localparam int ERR_W = SAMPLE_WIDTH + 1;
   localparam int CMP_W = (ERR_W > pidtr_pkg::DEAD_BAND_WIDTH) ? ERR_W
                                                                : pidtr_pkg::DEAD_BAND_WIDTH;
   localparam int ES_W  = pidtr_pkg::ERROR_SUM_WIDTH;
   localparam int SUM_W = ((ERR_W > ES_W) ? ERR_W : ES_W) + 1;
   localparam logic signed [SUM_W-1:0] ES_MAX = SUM_W'(32'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] ES_MIN = SUM_W'(32'sh8000_0000);

   // input register
   logic                           in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] ref_ff;
   logic signed [SAMPLE_WIDTH-1:0] meas_ff;
   logic                           dir_req_ff;

   // state
   logic signed [ES_W-1:0]         error_sum_ff;
   logic signed [ES_W-1:0]         error_sum_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_meas_ff;
   logic                           dir_state_ff;

   // stage outputs
   pidtr_pkg::pidtr_ctrl_type      ctrl_ff;
   pidtr_pkg::pidtr_ctrl_type      ctrl_in;
   logic signed [ERR_W-1:0]        err_ff;
   logic signed [ERR_W-1:0]        err_in;
   logic signed [ERR_W-1:0]        delta_ff;
   logic signed [ERR_W-1:0]        delta_in;

   logic signed [ERR_W-1:0]        raw_err;
   logic [ERR_W-1:0]               abs_err;
   logic                           in_band;
   logic signed [SUM_W-1:0]        sum_wide;
   logic                           step;
   logic                           toggle;

   // input register, loaded whenever the pipeline moves
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ref_ff     <= reference;
         meas_ff    <= measurement;
         dir_req_ff <= direction_request;
      end
   end

   // error with deadband
   always_comb begin
      raw_err = ERR_W'(ref_ff) - ERR_W'(meas_ff);
      abs_err = raw_err[ERR_W-1] ? ERR_W'(-raw_err) : ERR_W'(raw_err);
      in_band = CMP_W'(abs_err) <= CMP_W'(dead_band);
      err_in  = in_band ? '0 : raw_err;
   end

   // saturating running sum of the error
   always_comb begin
      sum_wide = SUM_W'(error_sum_ff) + SUM_W'(err_in);
      if (sum_wide > ES_MAX) begin
         error_sum_in = ES_MAX[ES_W-1:0];
      end else if (sum_wide < ES_MIN) begin
         error_sum_in = ES_MIN[ES_W-1:0];
      end else begin
         error_sum_in = sum_wide[ES_W-1:0];
      end
   end

   // direction flips when the request equals the present state
   always_comb begin
      step     = advance && in_valid_ff;
      toggle   = (dir_req_ff == dir_state_ff);
      delta_in = ERR_W'(prev_meas_ff) - ERR_W'(meas_ff);
      ctrl_in.valid             = in_valid_ff;
      ctrl_in.direction_flag    = toggle ? ~dir_state_ff : dir_state_ff;
      ctrl_in.direction_toggled = toggle;
   end

   // state update; any gain write clears the error sum and the previous measurement
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
         prev_meas_ff <= '0;
         dir_state_ff <= 1'b1;
      end else begin
         if (state_clear) begin
            error_sum_ff <= '0;
            prev_meas_ff <= '0;
         end else if (step) begin
            if (integral_on) begin
               error_sum_ff <= error_sum_in;
            end
            if (deriv_on) begin
               prev_meas_ff <= meas_ff;
            end
         end
         if (step) begin
            dir_state_ff <= ctrl_in.direction_flag;
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err_ff   <= err_in;
         delta_ff <= delta_in;
      end
   end

   assign ctrl       = ctrl_ff;
   assign error      = err_ff;
   assign error_sum  = error_sum_ff;
   assign meas_delta = delta_ff;

endmodule

// ===== rtl/core/pidtr_mult.sv =====
// pidtr_mult: the three gain products, each registered; depends on pidtr_pkg
module pidtr_mult #(
   parameter int SAMPLE_WIDTH = pidtr_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         advance,
   input  pidtr_pkg::pidtr_ctrl_type                    ctrl_in,
   input  logic signed [SAMPLE_WIDTH:0]                 error,
   input  logic signed [pidtr_pkg::ERROR_SUM_WIDTH-1:0] error_sum,
   input  logic signed [SAMPLE_WIDTH:0]                 meas_delta,
   input  logic signed [pidtr_pkg::GAIN_WIDTH-1:0]      prop_gain,
   input  logic signed [pidtr_pkg::GAIN_WIDTH-1:0]      integral_gain,
   input  logic signed [pidtr_pkg::GAIN_WIDTH-1:0]      deriv_gain,
   output pidtr_pkg::pidtr_ctrl_type                    ctrl_out,
   output logic signed [pidtr_pkg::GAIN_WIDTH+SAMPLE_WIDTH:0] p_term,
   output logic signed [pidtr_pkg::GAIN_WIDTH+pidtr_pkg::ERROR_SUM_WIDTH-1:0] i_term,
   output logic signed [pidtr_pkg::GAIN_WIDTH+SAMPLE_WIDTH:0] d_term
);

   localparam int PD_W = pidtr_pkg::GAIN_WIDTH + SAMPLE_WIDTH + 1;
   localparam int I_W  = pidtr_pkg::GAIN_WIDTH + pidtr_pkg::ERROR_SUM_WIDTH;

   pidtr_pkg::pidtr_ctrl_type ctrl_ff;
   logic signed [PD_W-1:0]    p_ff;
   logic signed [I_W-1:0]     i_ff;
   logic signed [PD_W-1:0]    d_ff;
   logic signed [PD_W-1:0]    p_in;
   logic signed [I_W-1:0]     i_in;
   logic signed [PD_W-1:0]    d_in;

   // exact signed products
   always_comb begin
      p_in = PD_W'(prop_gain) * PD_W'(error);
      i_in = I_W'(integral_gain) * I_W'(error_sum);
      d_in = PD_W'(deriv_gain) * PD_W'(meas_delta);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff <= p_in;
         i_ff <= i_in;
         d_ff <= d_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign p_term   = p_ff;
   assign i_term   = i_ff;
   assign d_term   = d_ff;

endmodule

// ===== rtl/core/pidtr_clamp.sv =====
// pidtr_clamp: sum of the three terms, clamp to the limit, truncation and the
// result register; depends on pidtr_pkg
module pidtr_clamp #(
   parameter int SAMPLE_WIDTH   = pidtr_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = pidtr_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         advance,
   input  pidtr_pkg::pidtr_ctrl_type                    ctrl_in,
   input  logic signed [pidtr_pkg::GAIN_WIDTH+SAMPLE_WIDTH:0] p_term,
   input  logic signed [pidtr_pkg::GAIN_WIDTH+pidtr_pkg::ERROR_SUM_WIDTH-1:0] i_term,
   input  logic signed [pidtr_pkg::GAIN_WIDTH+SAMPLE_WIDTH:0] d_term,
   input  logic [pidtr_pkg::LIMIT_WIDTH-1:0]            output_limit,
   output logic                                         out_valid,
   output logic [pidtr_pkg::DUTY_WIDTH-1:0]             duty,
   output logic signed [pidtr_pkg::DRIVE_WIDTH-1:0]     drive_value,
   output logic                                         direction_flag,
   output logic                                         direction_toggled
);

   localparam int PD_W  = pidtr_pkg::GAIN_WIDTH + SAMPLE_WIDTH + 1;
   localparam int I_W   = pidtr_pkg::GAIN_WIDTH + pidtr_pkg::ERROR_SUM_WIDTH;
   localparam int ACC_W = ((PD_W > I_W) ? PD_W : I_W) + 2;
   localparam int FRAC  = GAIN_FRAC_BITS + pidtr_pkg::SAMPLE_FRAC;
   localparam int DW    = pidtr_pkg::DUTY_WIDTH;
   localparam int VW    = pidtr_pkg::DRIVE_WIDTH;

   pidtr_pkg::pidtr_ctrl_type ctrl_ff;
   logic signed [ACC_W-1:0]   sum_ff;
   logic signed [ACC_W-1:0]   sum_in;

   logic                      neg;
   logic [ACC_W-1:0]          mag;
   logic [ACC_W-1:0]          limit_fixed;
   logic                      big;
   logic [DW-1:0]             imag;
   logic [VW-1:0]             drive_in;

   logic                      valid_ff;
   logic [DW-1:0]             duty_ff;
   logic [VW-1:0]             drive_ff;
   logic                      flag_ff;
   logic                      toggled_ff;

   // exact sum of the terms
   assign sum_in = ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(d_term);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

   // clamp on the magnitude, truncation toward zero
   always_comb begin
      neg         = sum_ff[ACC_W-1];
      mag         = neg ? ACC_W'(-sum_ff) : ACC_W'(sum_ff);
      limit_fixed = ACC_W'(output_limit) << FRAC;
      big         = mag >= limit_fixed;
      imag        = big ? output_limit : mag[FRAC +: DW];
      drive_in    = neg ? VW'(-{1'b0, imag}) : {1'b0, imag};
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctrl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         duty_ff    <= imag;
         drive_ff   <= drive_in;
         flag_ff    <= ctrl_ff.direction_flag;
         toggled_ff <= ctrl_ff.direction_toggled;
      end
   end

   assign out_valid         = valid_ff;
   assign duty              = duty_ff;
   assign drive_value       = drive_ff;
   assign direction_flag    = flag_ff;
   assign direction_toggled = toggled_ff;

endmodule

// ===== rtl/core/pid_torque_regulator_core.sv =====
// pid_torque_regulator_core: top level with configuration registers and stream ports
// depends on pidtr_pkg, pidtr_front, pidtr_mult, pidtr_clamp
//
// PID torque regulator with an error deadband. Each item on the req_ stream is one
// control tick (reference, measurement, direction request); each tick gives exactly
// one item on the rsp_ stream. The block takes one item per clock cycle when not
// stalled; a result passes the input register, error and state update, three
// gain products, sum, clamp into the result register. The integral sum, previous
// measurement and direction state close their loop within the single error stage,
// so items may follow each other in consecutive cycles. The whole pipeline stalls
// while a result waits on rsp_tready. Configuration writes are always taken; a write
// to any gain register clears the integral sum and the previous measurement, and
// registers should only be written while no item is in flight.
module pid_torque_regulator_core #(
   parameter int  SAMPLE_WIDTH   = pidtr_pkg::SAMPLE_WIDTH_DEF,
   parameter int  GAIN_FRAC_BITS = pidtr_pkg::GAIN_FRAC_BITS_DEF,
   localparam int REQ_W          = ((2 * SAMPLE_WIDTH + 1 + 7) / 8) * 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // input items
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // reference, measurement, direction_request, zero pad
   input  logic [REQ_W-1:0]                          req_tdata,
   // result items
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // duty, drive_value, direction_flag, direction_toggled, zero pad
   output logic [pidtr_pkg::RSP_TDATA_WIDTH-1:0]     rsp_tdata,
   // configuration writes
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [pidtr_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [pidtr_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   localparam int GW     = pidtr_pkg::GAIN_WIDTH;
   localparam int ERR_W  = SAMPLE_WIDTH + 1;
   localparam int PD_W   = GW + SAMPLE_WIDTH + 1;
   localparam int I_W    = GW + pidtr_pkg::ERROR_SUM_WIDTH;
   localparam int RSP_DW = pidtr_pkg::DUTY_WIDTH + pidtr_pkg::DRIVE_WIDTH + 2;

   // configuration registers
   logic signed [GW-1:0]                    prop_gain_ff;
   logic signed [GW-1:0]                    integral_gain_ff;
   logic signed [GW-1:0]                    deriv_gain_ff;
   logic [pidtr_pkg::DEAD_BAND_WIDTH-1:0]   dead_band_ff;
   logic [pidtr_pkg::LIMIT_WIDTH-1:0]       output_limit_ff;
   logic                                    csr_write;
   logic                                    gain_write;

   // pipeline
   logic                                    advance;
   pidtr_pkg::pidtr_ctrl_type               front_ctrl;
   pidtr_pkg::pidtr_ctrl_type               mult_ctrl;
   logic signed [ERR_W-1:0]                 error;
   logic signed [pidtr_pkg::ERROR_SUM_WIDTH-1:0] error_sum;
   logic signed [ERR_W-1:0]                 meas_delta;
   logic signed [PD_W-1:0]                  p_term;
   logic signed [I_W-1:0]                   i_term;
   logic signed [PD_W-1:0]                  d_term;
   logic                                    out_valid;
   logic [pidtr_pkg::DUTY_WIDTH-1:0]        duty;
   logic signed [pidtr_pkg::DRIVE_WIDTH-1:0] drive_value;
   logic                                    direction_flag;
   logic                                    direction_toggled;

   // configuration write decode
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      gain_write = 1'b0;
      if (csr_write) begin
         unique case (pidtr_pkg::csr_index_type'(csr_index))
            pidtr_pkg::CSR_PROP_GAIN,
            pidtr_pkg::CSR_INTEGRAL_GAIN,
            pidtr_pkg::CSR_DERIV_GAIN: gain_write = 1'b1;
            default:                   gain_write = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integral_gain_ff <= '0;
         deriv_gain_ff    <= '0;
         dead_band_ff     <= pidtr_pkg::DEAD_BAND_RESET;
         output_limit_ff  <= pidtr_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         unique case (pidtr_pkg::csr_index_type'(csr_index))
            pidtr_pkg::CSR_PROP_GAIN:     prop_gain_ff     <= csr_wdata[GW-1:0];
            pidtr_pkg::CSR_INTEGRAL_GAIN: integral_gain_ff <= csr_wdata[GW-1:0];
            pidtr_pkg::CSR_DERIV_GAIN:    deriv_gain_ff    <= csr_wdata[GW-1:0];
            pidtr_pkg::CSR_DEAD_BAND:
               dead_band_ff <= csr_wdata[pidtr_pkg::DEAD_BAND_WIDTH-1:0];
            pidtr_pkg::CSR_OUTPUT_LIMIT:
               output_limit_ff <= csr_wdata[pidtr_pkg::LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless a result is held
   assign advance    = !out_valid || rsp_tready;
   assign req_tready = advance;

   pidtr_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (req_tvalid),
      .reference         (req_tdata[SAMPLE_WIDTH-1:0]),
      .measurement       (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .direction_request (req_tdata[2*SAMPLE_WIDTH]),
      .integral_on       (integral_gain_ff != '0),
      .deriv_on          (deriv_gain_ff != '0),
      .dead_band         (dead_band_ff),
      .state_clear       (gain_write),
      .ctrl              (front_ctrl),
      .error             (error),
      .error_sum         (error_sum),
      .meas_delta        (meas_delta)
   );

   pidtr_mult #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_mult (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .ctrl_in       (front_ctrl),
      .error         (error),
      .error_sum     (error_sum),
      .meas_delta    (meas_delta),
      .prop_gain     (prop_gain_ff),
      .integral_gain (integral_gain_ff),
      .deriv_gain    (deriv_gain_ff),
      .ctrl_out      (mult_ctrl),
      .p_term        (p_term),
      .i_term        (i_term),
      .d_term        (d_term)
   );

   pidtr_clamp #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_clamp (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .ctrl_in           (mult_ctrl),
      .p_term            (p_term),
      .i_term            (i_term),
      .d_term            (d_term),
      .output_limit      (output_limit_ff),
      .out_valid         (out_valid),
      .duty              (duty),
      .drive_value       (drive_value),
      .direction_flag    (direction_flag),
      .direction_toggled (direction_toggled)
   );

   // result packing
   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {(pidtr_pkg::RSP_TDATA_WIDTH - RSP_DW)'(0),
                        direction_toggled, direction_flag, drive_value, duty};

endmodule
